// ===== rtl/plm_pkg.sv =====
// Shared widths, register indexes and beat types for the packet latency monitor.
`default_nettype none

package plm_pkg;

   localparam int VC_W        = 2;
   localparam int VC_SLOTS    = 1 << VC_W;
   localparam int LAT_W       = 31;
   localparam int SUM_W       = 48;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 31;
   localparam int NUM_VCS_DEF = 4;

   localparam logic [LAT_W-1:0] LAT_MAX = '1;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PKT_MODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT = 2'd2;

   typedef struct packed {
      logic             flit_valid;
      logic [VC_W-1:0]  vc;
      logic             is_head;
      logic             is_tail;
      logic [LAT_W-1:0] inject_time;
      logic [LAT_W-1:0] now_cycle;
   } flit_type;

   typedef struct packed {
      logic [LAT_W-1:0] warmup_cycles;
      logic             packet_mode;
      logic [LAT_W-1:0] stop_packet_count;
   } cfg_type;

   typedef struct packed {
      logic             read_enable;
      logic [VC_W-1:0]  read_vc;
      logic             packet_done;
      logic [LAT_W-1:0] pkt_latency;
      logic             latency_error;
      logic             stop_request;
   } rsp_type;

   typedef struct packed {
      logic [LAT_W-1:0] packets_received;
      logic [SUM_W-1:0] latency_sum;
      logic [LAT_W-1:0] latency_min;
      logic [LAT_W-1:0] latency_max;
   } stats_type;

endpackage

`default_nettype wire

// ===== rtl/plm_in_reg.sv =====
// Input register stage: captures one flit beat and holds it until the core takes it.
`default_nettype none

module plm_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire plm_pkg::flit_type req_flit,
   input  wire logic              take,
   output logic                   s_valid,
   output plm_pkg::flit_type      s_flit
);
   import plm_pkg::*;

   logic     loaded_ff;
   logic     loaded_in;
   flit_type flit_ff;

   // slot frees up in the same cycle the core takes the held beat
   assign req_ready = !loaded_ff || take;
   assign loaded_in = (req_valid && req_ready) ? 1'b1 : (take ? 1'b0 : loaded_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
      end
      if (req_valid && req_ready) begin
         flit_ff <= req_flit;
      end
   end

   assign s_valid = loaded_ff;
   assign s_flit  = flit_ff;

   a_take: assert property (@(posedge clock) disable iff (reset)
      take |-> loaded_ff)
      else $error("core took a beat from an empty input register");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (loaded_ff && !take) |=> (loaded_ff && $stable(flit_ff)))
      else $error("held flit lost or changed before the core took it");

   a_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> loaded_ff)
      else $error("accepted beat did not land in the input register");

endmodule

`default_nettype wire

// ===== rtl/plm_core.sv =====
// Latency core: per-channel head flags, statistics update and result register.
`default_nettype none

module plm_core #(
   parameter int NUM_VCS = plm_pkg::NUM_VCS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire plm_pkg::cfg_type  cfg,
   input  wire logic              s_valid,
   input  wire plm_pkg::flit_type s_flit,
   output logic                   take,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output plm_pkg::rsp_type       rsp,
   output plm_pkg::stats_type     stats
);
   import plm_pkg::*;

   logic [NUM_VCS-1:0]  head_seen_ff, head_seen_in;
   logic [VC_SLOTS-1:0] seen_ext;
   logic [LAT_W-1:0]    head_time_ff, head_time_in;
   logic [LAT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W:0]      sum_wide;
   logic [LAT_W-1:0]    min_ff, min_in;
   logic [LAT_W-1:0]    max_ff, max_in;
   logic [LAT_W-1:0]    stop_cnt_ff, stop_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic             hit, live, seen, close, err, done;
   logic [LAT_W-1:0] lat;

   // widen the flag vector to every code vc can carry; missing channels read 0
   for (genvar g = 0; g < VC_SLOTS; g++) begin : g_seen
      if (g < NUM_VCS) begin : g_real
         assign seen_ext[g] = head_seen_ff[g];
      end else begin : g_none
         assign seen_ext[g] = 1'b0;
      end
   end

   assign take = s_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      hit          = s_flit.flit_valid && (32'(s_flit.vc) < 32'(NUM_VCS));
      live         = hit && (s_flit.now_cycle >= cfg.warmup_cycles);
      head_time_in = (live && s_flit.is_head) ? s_flit.inject_time : head_time_ff;
      seen         = seen_ext[s_flit.vc] || (live && s_flit.is_head);
      close        = live && s_flit.is_tail && seen;
      err          = close && (s_flit.now_cycle < head_time_in);
      done         = close && !err;
      lat          = s_flit.now_cycle - head_time_in;

      for (int i = 0; i < NUM_VCS; i++) begin
         head_seen_in[i] = head_seen_ff[i];
         if (live && (32'(s_flit.vc) == 32'(i))) begin
            if (close) begin
               head_seen_in[i] = 1'b0;
            end else if (s_flit.is_head) begin
               head_seen_in[i] = 1'b1;
            end
         end
      end

      sum_wide    = {1'b0, sum_ff} + (SUM_W + 1)'(lat);
      count_in    = (done && count_ff != LAT_MAX) ? count_ff + 1'b1 : count_ff;
      sum_in      = done ? (sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0]) : sum_ff;
      min_in      = (done && lat < min_ff) ? lat : min_ff;
      max_in      = (done && lat > max_ff) ? lat : max_ff;
      stop_cnt_in = (done && cfg.packet_mode && stop_cnt_ff != LAT_MAX)
                    ? stop_cnt_ff + 1'b1 : stop_cnt_ff;

      rsp_in.read_enable   = hit;
      rsp_in.read_vc       = hit ? s_flit.vc : '0;
      rsp_in.packet_done   = done;
      rsp_in.pkt_latency   = done ? lat : '0;
      rsp_in.latency_error = err;
      rsp_in.stop_request  = done && cfg.packet_mode
                             && (stop_cnt_in >= cfg.stop_packet_count);

      rsp_valid_in = take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         head_seen_ff <= '0;
         head_time_ff <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         min_ff       <= LAT_MAX;
         max_ff       <= '0;
         stop_cnt_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            head_seen_ff <= head_seen_in;
            head_time_ff <= head_time_in;
            count_ff     <= count_in;
            sum_ff       <= sum_in;
            min_ff       <= min_in;
            max_ff       <= max_in;
            stop_cnt_ff  <= stop_cnt_in;
         end
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp                    = rsp_ff;
   assign stats.packets_received = count_ff;
   assign stats.latency_sum      = sum_ff;
   assign stats.latency_min      = min_ff;
   assign stats.latency_max      = max_ff;

   a_done_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.packet_done && rsp_ff.latency_error))
      else $error("packet counted and flagged as negative latency together");

   a_stop_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.stop_request) |-> rsp_ff.packet_done)
      else $error("stop request without a completed packet");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff <= max_ff))
      else $error("minimum latency above maximum after a packet");

   a_stats_hold: assert property (@(posedge clock) disable iff (reset)
      (!take && !reset) |=> ($stable(count_ff) && $stable(sum_ff)))
      else $error("statistics moved without a beat being taken");

   a_sum_grow: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (sum_ff >= $past(sum_ff)))
      else $error("latency total went down");

endmodule

`default_nettype wire

// ===== rtl/packet_latency_monitor.sv =====
// Top level of the packet latency monitor: csr registers, input stage and latency core.
`default_nettype none

//  channel | dir  | handshake             | carries
//  --------+------+-----------------------+------------------------------------------
//  req_    | in   | req_valid / req_ready | one flit beat (or idle tick) per beat
//  rsp_    | out  | rsp_valid / rsp_ready | strobe, latency, error, stats, stop
//  csr_    | in   | csr_valid / csr_ready | register index and write data
//
//  One beat per clock while rsp is not stalled; a req beat passes the input register
//  and then the result register before it is on rsp.
//  The whole statistics update (subtract, 48-bit saturating add, min/max) is
//  combinational logic between the input register and the result register.
//  Reset is synchronous; it clears the head flags, statistics and csr registers.
//  A stalled rsp holds the result; the input register then fills and req_ready drops.
//  csr writes are always taken (csr_ready high); an unknown index is dropped.

module packet_latency_monitor #(
   parameter int NUM_VCS = plm_pkg::NUM_VCS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // flit input
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_flit_valid,
   input  wire logic [plm_pkg::VC_W-1:0]         req_vc,
   input  wire logic                             req_is_head,
   input  wire logic                             req_is_tail,
   input  wire logic [plm_pkg::LAT_W-1:0]        req_inject_time,
   input  wire logic [plm_pkg::LAT_W-1:0]        req_now_cycle,
   // results
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_read_enable,
   output logic [plm_pkg::VC_W-1:0]              rsp_read_vc,
   output logic                                  rsp_packet_done,
   output logic [plm_pkg::LAT_W-1:0]             rsp_pkt_latency,
   output logic                                  rsp_latency_error,
   output logic [plm_pkg::LAT_W-1:0]             rsp_packets_received,
   output logic [plm_pkg::SUM_W-1:0]             rsp_latency_sum,
   output logic [plm_pkg::LAT_W-1:0]             rsp_latency_min,
   output logic [plm_pkg::LAT_W-1:0]             rsp_latency_max,
   output logic                                  rsp_stop_request,
   // register writes
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [plm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [plm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import plm_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   flit_type  req_flit, s_flit;
   logic      s_valid, take;
   rsp_type   rsp;
   stats_type stats;

   // csr writes must only land while the pipe is idle (the block does not enforce it), so no shadowing is needed
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WARMUP:     cfg_in.warmup_cycles     = csr_wdata;
            CSR_PKT_MODE:   cfg_in.packet_mode       = csr_wdata[0];
            CSR_STOP_COUNT: cfg_in.stop_packet_count = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_flit.flit_valid  = req_flit_valid;
   assign req_flit.vc          = req_vc;
   assign req_flit.is_head     = req_is_head;
   assign req_flit.is_tail     = req_is_tail;
   assign req_flit.inject_time = req_inject_time;
   assign req_flit.now_cycle   = req_now_cycle;

   plm_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_flit  (req_flit),
      .take      (take),
      .s_valid   (s_valid),
      .s_flit    (s_flit)
   );

   plm_core #(
      .NUM_VCS (NUM_VCS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .s_valid   (s_valid),
      .s_flit    (s_flit),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .stats     (stats)
   );

   // statistics come straight off the core's state; they only move when a beat
   // is loaded into the result register, so they hold while rsp is stalled
   assign rsp_read_enable      = rsp.read_enable;
   assign rsp_read_vc          = rsp.read_vc;
   assign rsp_packet_done      = rsp.packet_done;
   assign rsp_pkt_latency      = rsp.pkt_latency;
   assign rsp_latency_error    = rsp.latency_error;
   assign rsp_stop_request     = rsp.stop_request;
   assign rsp_packets_received = stats.packets_received;
   assign rsp_latency_sum      = stats.latency_sum;
   assign rsp_latency_min      = stats.latency_min;
   assign rsp_latency_max      = stats.latency_max;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_packets_received)
                                     && $stable(rsp_latency_sum)))
      else $error("stalled result changed its statistics");

   a_strobe_vc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_read_enable) |-> (rsp_read_vc == '0 && !rsp_packet_done
                                           && !rsp_latency_error))
      else $error("result activity without a read strobe");

   a_vc_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_enable) |-> (32'(rsp_read_vc) < 32'(NUM_VCS)))
      else $error("read strobe for a channel that does not exist");

endmodule

`default_nettype wire
